FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the shape pair overlap block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define SPOT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also runs through reset
`define SPOT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: sv/spot_pkg.sv
// ----------------------------------------------------------------------------
// spot_pkg
// Widths, field offsets, pair kinds and inter-stage structs for the shape
// pair overlap pipeline.
// ----------------------------------------------------------------------------
package spot_pkg;

    // Coordinate format: signed Q.8, extents one bit narrower and unsigned
    localparam int COORD_BITS = 24;
    localparam int EXT_BITS   = COORD_BITS - 1;
    // Edges, corners and centre +/- radius need one extra bit
    localparam int WIDE_BITS  = COORD_BITS + 1;
    // Difference of two wide values
    localparam int DIFF_BITS  = COORD_BITS + 2;
    localparam int SQ_BITS    = 2 * COORD_BITS;

    // Stream packing
    localparam int KIND_BITS    = 2;
    localparam int IN_BITS      = 4 * COORD_BITS + 4 * EXT_BITS;
    localparam int S_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = 8;

    localparam int OFF_AX = 0;
    localparam int OFF_AY = OFF_AX + COORD_BITS;
    localparam int OFF_AE = OFF_AY + COORD_BITS;
    localparam int OFF_AH = OFF_AE + EXT_BITS;
    localparam int OFF_BX = OFF_AH + EXT_BITS;
    localparam int OFF_BY = OFF_BX + COORD_BITS;
    localparam int OFF_BE = OFF_BY + COORD_BITS;
    localparam int OFF_BH = OFF_BE + EXT_BITS;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_CC   = 2'd0,   // circle a, circle b
        KIND_CR   = 2'd1,   // circle a, rectangle b
        KIND_RR   = 2'd2,   // rectangle a, rectangle b
        KIND_NONE = 2'd3    // unused code, never hits
    } pair_kind_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [EXT_BITS-1:0]   ext_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic        [DIFF_BITS-1:0]  mag_t;
    typedef logic        [COORD_BITS-1:0] rad_t;
    typedef logic        [SQ_BITS-1:0]    sq_t;
    typedef logic        [SQ_BITS:0]      sqsum_t;

    // One accepted transaction
    typedef struct packed {
        pair_kind_t kind;
        coord_t     ax;
        coord_t     ay;
        ext_t       ae;
        ext_t       ah;
        coord_t     bx;
        coord_t     by;
        ext_t       be;
        ext_t       bh;
    } shape_pair_t;

    // Early decision carried down the pipe
    typedef struct packed {
        logic fixed;    // answer already known
        logic hit;      // that answer
    } verdict_t;

    typedef struct packed {
        verdict_t verdict;
        wide_t    px;
        wide_t    qx;
        wide_t    py;
        wide_t    qy;
        rad_t     r;
    } bounds_out_t;

    typedef struct packed {
        verdict_t verdict;
        rad_t     m1;
        rad_t     m2;
        rad_t     r;
    } mag_out_t;

    typedef struct packed {
        verdict_t verdict;
        sq_t      s1;
        sq_t      s2;
        sq_t      r2;
    } square_out_t;

endpackage

FILE: sv/shape_pair_overlap_test.sv
// An accepted s_ transaction reaches m_tvalid through the register stages below.
// Throughput: one transaction per cycle while m_tready does not stall the output; four
//   register stages (bounds, magnitudes, squarers, compare) each take a new item every cycle unless stalled.
// A stage advances when it is empty or the stage after it advances.
// Reset (aresetn low, synchronous) empties every stage; no item is held.
// ----------------------------------------------------------------------------
// shape_pair_overlap_test
// Circle / rectangle overlap test on a stream of shape pairs, one hit flag
// per transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shape_pair_overlap_test
    import spot_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // tdata, low bit up: a_x, a_y, a_extent, a_height, b_x, b_y, b_extent,
    // b_height, zero pad
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    // tuser: cmd
    input  logic [KIND_BITS-1:0]    s_tuser,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // tdata, low bit up: hit, zero pad
    output logic [M_TDATA_BITS-1:0] m_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready
);

    shape_pair_t in_item;
    bounds_out_t bounds_data;
    mag_out_t    mag_data;
    square_out_t square_data;
    logic        valid_a, valid_b, valid_c;
    logic        en_a, en_b, en_c, en_d;
    logic        hit;

    // Unpack the input transaction
    always_comb begin
        in_item.kind = pair_kind_t'(s_tuser);
        in_item.ax   = s_tdata[OFF_AX +: COORD_BITS];
        in_item.ay   = s_tdata[OFF_AY +: COORD_BITS];
        in_item.ae   = s_tdata[OFF_AE +: EXT_BITS];
        in_item.ah   = s_tdata[OFF_AH +: EXT_BITS];
        in_item.bx   = s_tdata[OFF_BX +: COORD_BITS];
        in_item.by   = s_tdata[OFF_BY +: COORD_BITS];
        in_item.be   = s_tdata[OFF_BE +: EXT_BITS];
        in_item.bh   = s_tdata[OFF_BH +: EXT_BITS];
    end

    // Stage enables: fill bubbles, stall only when full downstream
    assign en_d     = !m_tvalid || m_tready;
    assign en_c     = !valid_c  || en_d;
    assign en_b     = !valid_b  || en_c;
    assign en_a     = !valid_a  || en_b;
    assign s_tready = en_a;

    spot_bounds u_bounds (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en_a),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .out_valid (valid_a),
        .out_data  (bounds_data)
    );

    spot_mag u_mag (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en_b),
        .in_valid  (valid_a),
        .in_data   (bounds_data),
        .out_valid (valid_b),
        .out_data  (mag_data)
    );

    spot_square u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en_c),
        .in_valid  (valid_b),
        .in_data   (mag_data),
        .out_valid (valid_c),
        .out_data  (square_data)
    );

    spot_decide u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en_d),
        .in_valid  (valid_c),
        .in_data   (square_data),
        .out_valid (m_tvalid),
        .out_hit   (hit)
    );

    assign m_tdata = {{(M_TDATA_BITS-1){1'b0}}, hit};

    // Back-pressure reaches the input only with every stage occupied
    `SPOT_ASSERT(a_full_stall, !s_tready |-> (valid_a && valid_b && valid_c && m_tvalid), "input stalled with a bubble in the pipe")
    // Reset empties the pipe
    `SPOT_ASSERT_RST(a_reset_empty, !aresetn |=> (!valid_a && !valid_b && !valid_c && !m_tvalid), "stage valid after reset")

endmodule

FILE: sv/spot_bounds.sv
// ----------------------------------------------------------------------------
// spot_bounds
// Stage 1: rectangle edges, bounding-box reject, corner selection and the
// rectangle-rectangle overlap. Picks the operand pairs for the distance test.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spot_bounds
    import spot_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  shape_pair_t in_item,
    output logic        out_valid,
    output bounds_out_t out_data
);

    logic        valid_reg;
    bounds_out_t data_reg;
    bounds_out_t data_next;

    wide_t ax_w, ay_w, bx_w, by_w;
    wide_t ae_w, ah_w, be_w, bh_w;
    wide_t a_right, a_bottom, b_right, b_bottom;
    wide_t cx_hi, cx_lo, cy_hi, cy_lo;
    logic  reject, x_left, x_right, y_above, y_below, overlap;
    rad_t  r_sum;

    // Sign / zero extension to the wide format
    always_comb begin
        ax_w = {in_item.ax[COORD_BITS-1], in_item.ax};
        ay_w = {in_item.ay[COORD_BITS-1], in_item.ay};
        bx_w = {in_item.bx[COORD_BITS-1], in_item.bx};
        by_w = {in_item.by[COORD_BITS-1], in_item.by};
        ae_w = {2'b00, in_item.ae};
        ah_w = {2'b00, in_item.ah};
        be_w = {2'b00, in_item.be};
        bh_w = {2'b00, in_item.bh};
    end

    // Edges and box tests
    always_comb begin
        a_right  = ax_w + ae_w;
        a_bottom = ay_w + ah_w;
        b_right  = bx_w + be_w;
        b_bottom = by_w + bh_w;
        cx_hi    = ax_w + ae_w;
        cx_lo    = ax_w - ae_w;
        cy_hi    = ay_w + ae_w;
        cy_lo    = ay_w - ae_w;
        reject   = (cx_hi < bx_w) || (cx_lo > b_right) ||
                   (cy_hi < by_w) || (cy_lo > b_bottom);
        x_left   = ax_w < bx_w;
        x_right  = ax_w > b_right;
        y_above  = ay_w < by_w;
        y_below  = ay_w > b_bottom;
        overlap  = !((bx_w > a_right) || (ax_w > b_right)) &&
                   !((by_w > a_bottom) || (ay_w > b_bottom));
        r_sum    = {1'b0, in_item.ae} + {1'b0, in_item.be};
    end

    // Per pair kind: early verdict and distance operands
    always_comb begin
        data_next.verdict.fixed = 1'b1;
        data_next.verdict.hit   = 1'b0;
        data_next.px            = ax_w;
        data_next.qx            = bx_w;
        data_next.py            = ay_w;
        data_next.qy            = by_w;
        data_next.r             = r_sum;
        case (in_item.kind)
            KIND_CC: begin
                data_next.verdict.fixed = 1'b0;
            end
            KIND_CR: begin
                data_next.qx = x_left  ? bx_w : b_right;
                data_next.qy = y_above ? by_w : b_bottom;
                data_next.r  = {1'b0, in_item.ae};
                if (reject) begin
                    data_next.verdict.hit = 1'b0;
                end else if (!(x_left || x_right) || !(y_above || y_below)) begin
                    // centre within the x or y span: edge contact
                    data_next.verdict.hit = 1'b1;
                end else begin
                    data_next.verdict.fixed = 1'b0;
                end
            end
            KIND_RR: begin
                data_next.verdict.hit = overlap;
            end
            default: begin
                data_next.verdict.hit = 1'b0;
            end
        endcase
    end

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Rectangle pairs are always settled in this stage
    `SPOT_ASSERT(a_rr_settled, (en && in_valid && in_item.kind == KIND_RR) |=> (out_valid && out_data.verdict.fixed), "rectangle pair left unsettled")
    `SPOT_ASSERT(a_cc_open, (en && in_valid && in_item.kind == KIND_CC) |=> (out_valid && !out_data.verdict.fixed), "circle pair settled early")

endmodule

FILE: sv/spot_mag.sv
// ----------------------------------------------------------------------------
// spot_mag
// Stage 2: axis distance magnitudes and the per-axis radius reject.
// Surviving magnitudes are narrowed to the radius width for squaring.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spot_mag
    import spot_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  bounds_out_t in_data,
    output logic        out_valid,
    output mag_out_t    out_data
);

    logic     valid_reg;
    mag_out_t data_reg;
    mag_out_t data_next;

    diff_t dx, dy;
    mag_t  mx, my, r_w;
    logic  near;

    // |p - q| on both axes
    always_comb begin
        dx   = {in_data.px[WIDE_BITS-1], in_data.px} - {in_data.qx[WIDE_BITS-1], in_data.qx};
        dy   = {in_data.py[WIDE_BITS-1], in_data.py} - {in_data.qy[WIDE_BITS-1], in_data.qy};
        mx   = dx[DIFF_BITS-1] ? mag_t'(-dx) : mag_t'(dx);
        my   = dy[DIFF_BITS-1] ? mag_t'(-dy) : mag_t'(dy);
        r_w  = {2'b00, in_data.r};
        near = (mx < r_w) && (my < r_w);
    end

    // An axis at or beyond the radius is a miss
    always_comb begin
        data_next.verdict = in_data.verdict;
        data_next.m1      = mx[COORD_BITS-1:0];
        data_next.m2      = my[COORD_BITS-1:0];
        data_next.r       = in_data.r;
        if (!in_data.verdict.fixed && !near) begin
            data_next.verdict.fixed = 1'b1;
            data_next.verdict.hit   = 1'b0;
        end
    end

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Narrowing is only safe below the radius
    `SPOT_ASSERT(a_mag_fits, (out_valid && !out_data.verdict.fixed) |-> ((out_data.m1 < out_data.r) && (out_data.m2 < out_data.r)), "open item with magnitude not below radius")

endmodule

FILE: sv/spot_square.sv
// ----------------------------------------------------------------------------
// spot_square
// Stage 3: three parallel squarers for both axis distances and the radius.
// ----------------------------------------------------------------------------
module spot_square
    import spot_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  mag_out_t    in_data,
    output logic        out_valid,
    output square_out_t out_data
);

    logic        valid_reg;
    square_out_t data_reg;
    square_out_t data_next;

    // Squares, full product width
    always_comb begin
        data_next.verdict = in_data.verdict;
        data_next.s1      = sq_t'(in_data.m1) * sq_t'(in_data.m1);
        data_next.s2      = sq_t'(in_data.m2) * sq_t'(in_data.m2);
        data_next.r2      = sq_t'(in_data.r) * sq_t'(in_data.r);
    end

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/spot_decide.sv
// ----------------------------------------------------------------------------
// spot_decide
// Stage 4: sum of squares against squared radius, merge with the early
// verdict. Its register is the output register of the block.
// ----------------------------------------------------------------------------
module spot_decide
    import spot_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  square_out_t in_data,
    output logic        out_valid,
    output logic        out_hit
);

    logic   valid_reg;
    logic   hit_reg;
    logic   hit_next;
    sqsum_t sum;

    // Strict compare with a carry bit on the sum
    always_comb begin
        sum      = {1'b0, in_data.s1} + {1'b0, in_data.s2};
        hit_next = in_data.verdict.fixed ? in_data.verdict.hit
                                         : (sum < {1'b0, in_data.r2});
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_hit   = hit_reg;

endmodule
